[rtl/tts_pkg.sv]
package tts_pkg;

   localparam int MAX_TASKS_DEFAULT = 8;
   localparam int DISPATCH_LIMIT    = 8;
   localparam int RUN_COUNT_MAX     = 255;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_DELETE   = 2'd1,
      OP_TICK     = 2'd2,
      OP_DISPATCH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_NO_TASK = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_FULL       = 2'd1,
      ERR_BAD_DELETE = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      ALU_LOAD,
      ALU_CLEAR,
      ALU_TICK,
      ALU_DISPATCH
   } alu_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_DELETE,
      ST_TICK,
      ST_DISPATCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  handler_id;
      logic [15:0] start_delay;
      logic [15:0] period;
      logic [15:0] reload;
      logic [2:0]  slot_index;
   } req_type;

   typedef struct packed {
      op_type      op_echo;
      status_type  status;
      logic [3:0]  slot;
      logic [7:0]  task_handler;
      logic        nothing_ready;
      logic        last;
      err_type     error_code;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  handler;
      logic [15:0] delay;
      logic [15:0] period;
      logic [15:0] reload;
      logic [7:0]  run_count;
   } entry_type;

   typedef struct packed {
      logic       we;
      alu_op_type alu_op;
   } ctrl_type;

endpackage

[rtl/tts_table.sv]
module tts_table #(
   parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEFAULT,
   parameter int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_W-1:0]    addr,
   input  logic                we,
   input  tts_pkg::entry_type  entry_in,
   output tts_pkg::entry_type  rd_entry
);

   tts_pkg::entry_type tbl_ff [MAX_TASKS];

   assign rd_entry = tbl_ff[addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            tbl_ff[i].valid     <= 1'b0;
            tbl_ff[i].run_count <= '0;
         end
      end else if (we) begin
         tbl_ff[addr] <= entry_in;
      end
   end

endmodule

[rtl/tts_slot_alu.sv]
module tts_slot_alu (
   input  tts_pkg::alu_op_type alu_op,
   input  tts_pkg::entry_type  entry,
   input  tts_pkg::req_type    req,
   output tts_pkg::entry_type  result
);

   always_comb begin
      result = entry;
      unique case (alu_op)
         tts_pkg::ALU_LOAD: begin
            result.valid     = 1'b1;
            result.handler   = req.handler_id;
            result.delay     = req.start_delay;
            result.period    = req.period;
            result.reload    = req.reload;
            result.run_count = '0;
         end
         tts_pkg::ALU_CLEAR: begin
            result.valid     = 1'b0;
            result.delay     = '0;
            result.period    = '0;
            result.run_count = '0;
         end
         tts_pkg::ALU_TICK: begin
            if (entry.valid) begin
               if (entry.delay == '0) begin
                  if (entry.run_count != 8'(tts_pkg::RUN_COUNT_MAX)) begin
                     result.run_count = entry.run_count + 8'd1;
                  end
                  if (entry.reload != '0) begin
                     result.delay = entry.reload;
                  end
               end else begin
                  result.delay = entry.delay - 16'd1;
               end
            end
         end
         tts_pkg::ALU_DISPATCH: begin
            result.run_count = entry.run_count - 8'd1;
            if (entry.period == '0) begin
               result.valid     = 1'b0;
               result.delay     = '0;
               result.run_count = '0;
            end
         end
         default: begin
            result = entry;
         end
      endcase
   end

endmodule

[rtl/tts_sequencer.sv]
module tts_sequencer #(
   parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEFAULT,
   parameter int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  tts_pkg::req_type    req,
   input  tts_pkg::entry_type  rd_entry,
   output logic [IDX_W-1:0]    addr,
   output tts_pkg::ctrl_type   ctrl,
   output tts_pkg::req_type    req_q,
   output logic                rsp_valid,
   output tts_pkg::rsp_type    rsp
);

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_TASKS - 1);
   localparam logic [3:0]       SLOT_FULL = 4'(MAX_TASKS);
   localparam logic [3:0]       LIMIT     = 4'(tts_pkg::DISPATCH_LIMIT);

   tts_pkg::state_type state_ff, state_in;
   tts_pkg::req_type   req_ff, req_in;
   tts_pkg::err_type   sticky_ff, sticky_in;
   tts_pkg::rsp_type   rsp_ff, rsp_in;
   logic [IDX_W-1:0]   ctr_ff, ctr_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [3:0]         pend_slot_ff, pend_slot_in;
   logic [7:0]         pend_handler_ff, pend_handler_in;
   logic [3:0]         count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic               at_last;
   logic               ready;
   logic               limit_hit;
   logic [7:0]         ctr_ext;
   logic [7:0]         del_ext;
   logic               del_in_range;

   assign busy         = (state_ff != tts_pkg::ST_IDLE);
   assign accept       = start && !busy;
   assign at_last      = (ctr_ff == LAST_SLOT);
   assign ready        = (rd_entry.run_count != '0);
   assign limit_hit    = ready && ((count_ff + 4'd1) == LIMIT);
   assign ctr_ext      = 8'(ctr_ff);
   assign del_ext      = 8'(req_ff.slot_index);
   assign del_in_range = (del_ext < 8'(MAX_TASKS));
   assign req_q        = req_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp          = rsp_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tts_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req.op)
                  tts_pkg::OP_ADD:      state_in = tts_pkg::ST_ADD;
                  tts_pkg::OP_DELETE:   state_in = tts_pkg::ST_DELETE;
                  tts_pkg::OP_TICK:     state_in = tts_pkg::ST_TICK;
                  tts_pkg::OP_DISPATCH: state_in = tts_pkg::ST_DISPATCH;
                  default:              state_in = tts_pkg::ST_IDLE;
               endcase
            end
         end
         tts_pkg::ST_ADD: begin
            if (!rd_entry.valid || at_last) begin
               state_in = tts_pkg::ST_IDLE;
            end
         end
         tts_pkg::ST_DELETE: begin
            state_in = tts_pkg::ST_IDLE;
         end
         tts_pkg::ST_TICK: begin
            if (at_last) begin
               state_in = tts_pkg::ST_IDLE;
            end
         end
         tts_pkg::ST_DISPATCH: begin
            if (limit_hit || at_last) begin
               state_in = tts_pkg::ST_FINISH;
            end
         end
         tts_pkg::ST_FINISH: begin
            state_in = tts_pkg::ST_IDLE;
         end
         default: begin
            state_in = tts_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_in          = req_ff;
      sticky_in       = sticky_ff;
      ctr_in          = ctr_ff;
      pend_valid_in   = pend_valid_ff;
      pend_slot_in    = pend_slot_ff;
      pend_handler_in = pend_handler_ff;
      count_in        = count_ff;
      addr            = ctr_ff;
      ctrl.we         = 1'b0;
      ctrl.alu_op     = tts_pkg::ALU_TICK;
      rsp_valid_in    = 1'b0;
      rsp_in          = '0;
      rsp_in.op_echo  = req_ff.op;
      rsp_in.status   = tts_pkg::STATUS_OK;
      rsp_in.last     = 1'b1;
      unique case (state_ff)
         tts_pkg::ST_IDLE: begin
            if (accept) begin
               req_in        = req;
               ctr_in        = '0;
               pend_valid_in = 1'b0;
               count_in      = '0;
            end
         end
         tts_pkg::ST_ADD: begin
            if (!rd_entry.valid) begin
               ctrl.we      = 1'b1;
               ctrl.alu_op  = tts_pkg::ALU_LOAD;
               rsp_valid_in = 1'b1;
               rsp_in.slot  = ctr_ext[3:0];
            end else if (at_last) begin
               sticky_in     = tts_pkg::ERR_FULL;
               rsp_valid_in  = 1'b1;
               rsp_in.status = tts_pkg::STATUS_FULL;
               rsp_in.slot   = SLOT_FULL;
            end else begin
               ctr_in = ctr_ff + IDX_W'(1);
            end
         end
         tts_pkg::ST_DELETE: begin
            addr         = del_ext[IDX_W-1:0];
            rsp_valid_in = 1'b1;
            rsp_in.slot  = del_ext[3:0];
            if (del_in_range) begin
               ctrl.we     = 1'b1;
               ctrl.alu_op = tts_pkg::ALU_CLEAR;
            end
            if (!del_in_range || !rd_entry.valid) begin
               sticky_in     = tts_pkg::ERR_BAD_DELETE;
               rsp_in.status = tts_pkg::STATUS_NO_TASK;
            end
         end
         tts_pkg::ST_TICK: begin
            ctrl.we     = 1'b1;
            ctrl.alu_op = tts_pkg::ALU_TICK;
            ctr_in      = ctr_ff + IDX_W'(1);
            if (at_last) begin
               rsp_valid_in = 1'b1;
            end
         end
         tts_pkg::ST_DISPATCH: begin
            ctr_in = ctr_ff + IDX_W'(1);
            if (ready) begin
               ctrl.we     = 1'b1;
               ctrl.alu_op = tts_pkg::ALU_DISPATCH;
               if (pend_valid_ff) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.slot         = pend_slot_ff;
                  rsp_in.task_handler = pend_handler_ff;
                  rsp_in.last         = 1'b0;
               end
               pend_valid_in   = 1'b1;
               pend_slot_in    = ctr_ext[3:0];
               pend_handler_in = rd_entry.handler;
               count_in        = count_ff + 4'd1;
            end
         end
         tts_pkg::ST_FINISH: begin
            rsp_valid_in = 1'b1;
            if (pend_valid_ff) begin
               rsp_in.slot         = pend_slot_ff;
               rsp_in.task_handler = pend_handler_ff;
            end else begin
               rsp_in.nothing_ready = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
      rsp_in.error_code = sticky_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tts_pkg::ST_IDLE;
         sticky_ff     <= tts_pkg::ERR_NONE;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
         ctr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         sticky_ff     <= sticky_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
         ctr_ff        <= ctr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff          <= req_in;
      rsp_ff          <= rsp_in;
      pend_slot_ff    <= pend_slot_in;
      pend_handler_ff <= pend_handler_in;
   end

endmodule

[rtl/tick_task_scheduler_table_unit.sv]
// A transaction is taken when start is high and busy is low; busy then stays high until done.
// Add, tick and dispatch walk the table from slot 0; delete visits only the requested slot.
// One table slot per cycle is read and, where needed, rewritten through the shared slot unit.
// Add, delete and tick results appear in the cycle after the slot that decides them; a dispatch
// result waits for the next ready slot or the end of the walk. Results cannot be held off.
// Synchronous reset empties the table, clears the sticky error and returns to idle.
module tick_task_scheduler_table_unit #(
   parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tts_pkg::req_type req,
   output logic             rsp_valid,
   output tts_pkg::rsp_type rsp
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   logic [IDX_W-1:0]   addr;
   tts_pkg::ctrl_type  ctrl;
   tts_pkg::req_type   req_q;
   tts_pkg::entry_type rd_entry;
   tts_pkg::entry_type wr_entry;

   tts_sequencer #(
      .MAX_TASKS (MAX_TASKS),
      .IDX_W     (IDX_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rd_entry  (rd_entry),
      .addr      (addr),
      .ctrl      (ctrl),
      .req_q     (req_q),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   tts_slot_alu u_alu (
      .alu_op (ctrl.alu_op),
      .entry  (rd_entry),
      .req    (req_q),
      .result (wr_entry)
   );

   tts_table #(
      .MAX_TASKS (MAX_TASKS),
      .IDX_W     (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .addr     (addr),
      .we       (ctrl.we),
      .entry_in (wr_entry),
      .rd_entry (rd_entry)
   );

endmodule

[rtl/tts_checker.sv]
module tts_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input tts_pkg::rsp_type rsp
);

   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted transaction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.last |=> !rsp_valid)
      else $error("result followed the final result of a transaction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.op_echo != tts_pkg::OP_DISPATCH |-> rsp.last)
      else $error("non-dispatch transaction gave more than one result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.nothing_ready |-> rsp.last && rsp.op_echo == tts_pkg::OP_DISPATCH)
      else $error("nothing-ready flag on an unexpected result");

endmodule

bind tick_task_scheduler_table_unit tts_checker u_tts_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp       (rsp)
);
